### rtl/msx_pkg.sv
// shared constants, opcode codes and stage structs for the mips subset executor
package msx_pkg;

   localparam int unsigned DATA_WORDS = 64;
   localparam int unsigned DM_AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int unsigned RF_DEPTH   = 32;
   localparam int unsigned RF_AW      = 5;

   localparam logic [31:0] BREAK_WORD      = 32'h3C00000D;
   localparam logic [31:0] START_PC_RESET  = 32'd64;
   localparam logic [31:0] DATA_BASE_RESET = 32'd0;
   localparam logic [31:0] PC_STEP         = 32'd4;

   // instruction categories, bits 31..29
   localparam logic [2:0] CAT_CTRL  = 3'b001;
   localparam logic [2:0] CAT_ALU_R = 3'b010;
   localparam logic [2:0] CAT_ALU_I = 3'b100;

   // control / memory opcodes
   localparam logic [2:0] OP_NOP  = 3'd0;
   localparam logic [2:0] OP_J    = 3'd1;
   localparam logic [2:0] OP_BEQ  = 3'd2;
   localparam logic [2:0] OP_BNE  = 3'd3;
   localparam logic [2:0] OP_BGTZ = 3'd4;
   localparam logic [2:0] OP_SW   = 3'd5;
   localparam logic [2:0] OP_LW   = 3'd6;

   // register alu opcodes
   localparam logic [2:0] OP_XOR  = 3'd0;
   localparam logic [2:0] OP_MUL  = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_AND  = 3'd4;
   localparam logic [2:0] OP_OR   = 3'd5;
   localparam logic [2:0] OP_ADDU = 3'd6;
   localparam logic [2:0] OP_SUBU = 3'd7;

   // immediate alu opcodes
   localparam logic [2:0] OP_ORI  = 3'd0;
   localparam logic [2:0] OP_XORI = 3'd1;
   localparam logic [2:0] OP_ADDI = 3'd2;
   localparam logic [2:0] OP_SUBI = 3'd3;
   localparam logic [2:0] OP_ANDI = 3'd4;
   localparam logic [2:0] OP_SRL  = 3'd5;
   localparam logic [2:0] OP_SRA  = 3'd6;
   localparam logic [2:0] OP_SLL  = 3'd7;

   // configuration register indexes
   localparam logic CSR_START_PC  = 1'b0;
   localparam logic CSR_DATA_BASE = 1'b1;

   // operands and decode inputs of the execute stage
   typedef struct packed {
      logic             func;
      logic [31:0]      instr;
      logic [5:0]       load_index;
      logic [31:0]      load_value;
      logic [31:0]      op1;
      logic [31:0]      op2;
      logic [31:0]      product;
      logic [31:0]      br_ofs;
      logic             mem_hit;
      logic [DM_AW-1:0] mem_idx;
   } exec_in_type;

   // outcome of one beat, also the state commit
   typedef struct packed {
      logic [31:0]      next_pc;
      logic             halted;
      logic             illegal;
      logic             branch_taken;
      logic             reg_write;
      logic [4:0]       reg_index;
      logic [31:0]      reg_value;
      logic             mem_write;
      logic [DM_AW-1:0] mem_index;
      logic [31:0]      mem_value;
   } exec_out_type;

endpackage

### rtl/msx_regfile.sv
// 32 x 32 register file, two registered read ports, one write port, reset-clear valid bits
module msx_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   import msx_pkg::*;

   logic [31:0]         mem [RF_DEPTH];
   logic [RF_DEPTH-1:0] vld_ff;
   logic [31:0]         rd_a_ff;
   logic [31:0]         rd_b_ff;
   logic                rd_vld_a_ff;
   logic                rd_vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_vld_a_ff <= 1'b0;
         rd_vld_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_a_ff <= vld_ff[rd_addr_a];
            rd_vld_b_ff <= vld_ff[rd_addr_b];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data_a = rd_vld_a_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_vld_b_ff ? rd_b_ff : '0;

endmodule

### rtl/msx_dmem.sv
// data memory, one registered read port and one write port, reset-clear valid bits
module msx_dmem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [msx_pkg::DM_AW-1:0] rd_addr,
   output logic [31:0]               rd_data,
   input  logic                      wr_en,
   input  logic [msx_pkg::DM_AW-1:0] wr_addr,
   input  logic [31:0]               wr_data
);
   import msx_pkg::*;

   logic [31:0]           mem [DATA_WORDS];
   logic [DATA_WORDS-1:0] vld_ff;
   logic [31:0]           rd_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

### rtl/msx_exec.sv
// execute stage: decode, alu, branch resolve and write selection for one beat
module msx_exec (
   input  msx_pkg::exec_in_type  ex,
   input  logic [31:0]           pc,
   input  logic                  halt,
   input  logic [31:0]           load_data,
   output msx_pkg::exec_out_type res
);
   import msx_pkg::*;

   logic [2:0]  cat;
   logic [2:0]  op;
   logic [4:0]  fld_a;
   logic [4:0]  fld_b;
   logic [4:0]  sa;
   logic [31:0] zimm;
   logic [31:0] simm;
   logic [31:0] seq;
   logic [31:0] btgt;

   always_comb begin
      cat   = ex.instr[31:29];
      op    = ex.instr[28:26];
      fld_a = ex.instr[25:21];
      fld_b = ex.instr[20:16];
      sa    = ex.instr[4:0];
      zimm  = {16'h0000, ex.instr[15:0]};
      simm  = {{16{ex.instr[15]}}, ex.instr[15:0]};
      seq   = pc + PC_STEP;
      btgt  = pc + ex.br_ofs;

      res         = '0;
      res.next_pc = pc;
      res.halted  = halt;

      if (ex.func) begin
         // preload, taken even while halted
         if (32'(ex.load_index) < DATA_WORDS) begin
            res.mem_write = 1'b1;
            res.mem_index = DM_AW'(ex.load_index);
            res.mem_value = ex.load_value;
         end
      end else if (!halt) begin
         res.next_pc = seq;
         if (ex.instr == BREAK_WORD) begin
            res.halted  = 1'b1;
            res.next_pc = pc;
         end else begin
            unique case (cat)
               CAT_CTRL: begin
                  unique case (op)
                     OP_NOP: begin
                     end
                     OP_J: begin
                        res.next_pc      = {seq[31:28], ex.instr[25:0], 2'b00};
                        res.branch_taken = 1'b1;
                     end
                     OP_BEQ: begin
                        if (ex.op1 == ex.op2) begin
                           res.next_pc      = btgt;
                           res.branch_taken = 1'b1;
                        end
                     end
                     OP_BNE: begin
                        if (ex.op1 != ex.op2) begin
                           res.next_pc      = btgt;
                           res.branch_taken = 1'b1;
                        end
                     end
                     OP_BGTZ: begin
                        if ($signed(ex.op1) > 32'sd0) begin
                           res.next_pc      = btgt;
                           res.branch_taken = 1'b1;
                        end
                     end
                     OP_SW: begin
                        if (ex.mem_hit) begin
                           res.mem_write = 1'b1;
                           res.mem_index = ex.mem_idx;
                           res.mem_value = ex.op2;
                        end
                     end
                     OP_LW: begin
                        if (ex.mem_hit) begin
                           res.reg_write = 1'b1;
                           res.reg_index = fld_b;
                           res.reg_value = load_data;
                        end
                     end
                     default: begin
                        res.illegal = 1'b1;
                     end
                  endcase
               end
               CAT_ALU_R: begin
                  res.reg_write = 1'b1;
                  res.reg_index = fld_a;
                  unique case (op)
                     OP_XOR:  res.reg_value = ex.op1 ^ ex.op2;
                     OP_MUL:  res.reg_value = ex.product;
                     OP_ADD:  res.reg_value = ex.op1 + ex.op2;
                     OP_SUB:  res.reg_value = ex.op1 - ex.op2;
                     OP_AND:  res.reg_value = ex.op1 & ex.op2;
                     OP_OR:   res.reg_value = ex.op1 | ex.op2;
                     OP_ADDU: res.reg_value = ex.op1 + ex.op2;
                     OP_SUBU: res.reg_value = ex.op1 - ex.op2;
                     default: res.reg_value = '0;
                  endcase
               end
               CAT_ALU_I: begin
                  res.reg_write = 1'b1;
                  res.reg_index = fld_a;
                  unique case (op)
                     OP_ORI:  res.reg_value = ex.op1 | zimm;
                     OP_XORI: res.reg_value = ex.op1 ^ zimm;
                     OP_ADDI: res.reg_value = ex.op1 + simm;
                     OP_SUBI: res.reg_value = ex.op1 - simm;
                     OP_ANDI: res.reg_value = ex.op1 & simm;
                     OP_SRL:  res.reg_value = ex.op1 >> sa;
                     OP_SRA:  res.reg_value = $unsigned($signed(ex.op1) >>> sa);
                     OP_SLL:  res.reg_value = ex.op1 << sa;
                     default: res.reg_value = '0;
                  endcase
               end
               default: begin
                  res.illegal = 1'b1;
               end
            endcase
         end
      end
   end

endmodule

### rtl/mips_subset_instruction_executor_core.sv
// top level: three-stage executor pipeline with operand forwarding and state commit
//
//  port group   direction  beat / write condition          contents
//  req_*        in         req_valid & !req_stall          func, instr, load index/value
//  rsp_*        out        rsp_valid & !rsp_stall          next pc, flags, reg/mem writes
//  csr_*        in         csr_write                       start_pc (0), data_base (1)
//
//  one beat per cycle sustained while rsp_stall is low; a result passes the register file
//  read at the request edge, the operand/address stage with the multiplier and data memory
//  read, and execute and commit into the result register
//  forwarding from the execute stage and the last committed writes removes every hazard
//  reset is synchronous; register file and data memory read as zero until written
//  a stalled result holds all stages behind it once they are full
module mips_subset_instruction_executor_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_instr,
   input  logic [5:0]  req_load_index,
   input  logic [31:0] req_load_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_illegal,
   output logic        rsp_branch_taken,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_write,
   output logic [5:0]  rsp_mem_index,
   output logic [31:0] rsp_mem_value,

   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import msx_pkg::*;

   // handshake
   logic accept;
   logic out_ready;
   logic s2_adv;
   logic s2_free;
   logic s1_adv;
   logic s1_free;

   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic out_vld_ff, out_vld_in;

   // architectural state
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [31:0] data_base_ff, data_base_in;

   // last committed writes, for reads issued at the same edge
   logic             rwb_vld_ff, rwb_vld_in;
   logic [4:0]       rwb_idx_ff;
   logic [31:0]      rwb_val_ff;
   logic             dwb_vld_ff, dwb_vld_in;
   logic [DM_AW-1:0] dwb_idx_ff;
   logic [31:0]      dwb_val_ff;

   // request decode for register reads
   logic [2:0] req_cat;
   logic [4:0] req_p1;
   logic [4:0] req_p2;
   logic [31:0] req_immoff;

   // stage 1
   logic        s1_func_ff;
   logic [31:0] s1_instr_ff;
   logic [5:0]  s1_load_index_ff;
   logic [31:0] s1_load_value_ff;
   logic [31:0] s1_immoff_ff;
   logic [4:0]  s1_p1_ff;
   logic [4:0]  s1_p2_ff;
   logic [31:0] rf_rd1;
   logic [31:0] rf_rd2;
   logic [31:0] op1;
   logic [31:0] op2;
   logic [31:0] product;
   logic [31:0] mem_off;
   exec_in_type s1_out;

   // stage 2
   exec_in_type  ex_in_ff;
   exec_out_type ex_res;
   logic [31:0]  dm_rdata;
   logic [31:0]  load_data;

   // result register
   exec_out_type out_ff;

   assign out_ready = !out_vld_ff || !rsp_stall;
   assign s2_adv    = s2_vld_ff && out_ready;
   assign s2_free   = !s2_vld_ff || out_ready;
   assign s1_adv    = s1_vld_ff && s2_free;
   assign s1_free   = !s1_vld_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign s1_vld_in  = accept || (s1_vld_ff && !s2_free);
   assign s2_vld_in  = s1_adv || (s2_vld_ff && !out_ready);
   assign out_vld_in = s2_adv || (out_vld_ff && rsp_stall);

   // read port selection follows the instruction format
   always_comb begin
      req_cat = req_instr[31:29];
      req_p1  = (req_cat == CAT_ALU_R || req_cat == CAT_ALU_I) ? req_instr[20:16]
                                                               : req_instr[25:21];
      req_p2  = (req_cat == CAT_ALU_R) ? req_instr[15:11] : req_instr[20:16];
      // folds the base out of the load/store address add
      req_immoff = {{16{req_instr[15]}}, req_instr[15:0]} - data_base_ff;
   end

   msx_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_p1),
      .rd_addr_b (req_p2),
      .rd_data_a (rf_rd1),
      .rd_data_b (rf_rd2),
      .wr_en     (s2_adv && ex_res.reg_write),
      .wr_addr   (ex_res.reg_index),
      .wr_data   (ex_res.reg_value)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff       <= req_func;
         s1_instr_ff      <= req_instr;
         s1_load_index_ff <= req_load_index;
         s1_load_value_ff <= req_load_value;
         s1_immoff_ff     <= req_immoff;
         s1_p1_ff         <= req_p1;
         s1_p2_ff         <= req_p2;
      end
   end

   // operands: execute stage result first, then the write committed at the read edge
   always_comb begin
      if (s2_vld_ff && ex_res.reg_write && ex_res.reg_index == s1_p1_ff) begin
         op1 = ex_res.reg_value;
      end else if (rwb_vld_ff && rwb_idx_ff == s1_p1_ff) begin
         op1 = rwb_val_ff;
      end else begin
         op1 = rf_rd1;
      end
      if (s2_vld_ff && ex_res.reg_write && ex_res.reg_index == s1_p2_ff) begin
         op2 = ex_res.reg_value;
      end else if (rwb_vld_ff && rwb_idx_ff == s1_p2_ff) begin
         op2 = rwb_val_ff;
      end else begin
         op2 = rf_rd2;
      end
   end

   assign product = op1 * op2;
   assign mem_off = op1 + s1_immoff_ff;

   always_comb begin
      s1_out.func       = s1_func_ff;
      s1_out.instr      = s1_instr_ff;
      s1_out.load_index = s1_load_index_ff;
      s1_out.load_value = s1_load_value_ff;
      s1_out.op1        = op1;
      s1_out.op2        = op2;
      s1_out.product    = product;
      s1_out.br_ofs     = {{14{s1_instr_ff[15]}}, s1_instr_ff[15:0], 2'b00} + PC_STEP;
      s1_out.mem_hit    = (mem_off[1:0] == 2'b00) &&
                          ({2'b00, mem_off[31:2]} < 32'(DATA_WORDS));
      s1_out.mem_idx    = DM_AW'(mem_off[31:2]);
   end

   msx_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_adv),
      .rd_addr (s1_out.mem_idx),
      .rd_data (dm_rdata),
      .wr_en   (s2_adv && ex_res.mem_write),
      .wr_addr (ex_res.mem_index),
      .wr_data (ex_res.mem_value)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         ex_in_ff <= s1_out;
      end
   end

   assign load_data = (dwb_vld_ff && dwb_idx_ff == ex_in_ff.mem_idx) ? dwb_val_ff : dm_rdata;

   msx_exec u_exec (
      .ex        (ex_in_ff),
      .pc        (pc_ff),
      .halt      (halt_ff),
      .load_data (load_data),
      .res       (ex_res)
   );

   // commit and configuration
   always_comb begin
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      data_base_in = data_base_ff;
      rwb_vld_in   = rwb_vld_ff;
      dwb_vld_in   = dwb_vld_ff;
      if (s2_adv) begin
         pc_in   = ex_res.next_pc;
         halt_in = ex_res.halted;
         if (ex_res.reg_write) begin
            rwb_vld_in = 1'b1;
         end
         if (ex_res.mem_write) begin
            dwb_vld_in = 1'b1;
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_PC:  pc_in        = csr_data;
            CSR_DATA_BASE: data_base_in = csr_data;
            default:       pc_in        = pc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         pc_ff        <= START_PC_RESET;
         halt_ff      <= 1'b0;
         data_base_ff <= DATA_BASE_RESET;
         rwb_vld_ff   <= 1'b0;
         dwb_vld_ff   <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         out_vld_ff   <= out_vld_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         data_base_ff <= data_base_in;
         rwb_vld_ff   <= rwb_vld_in;
         dwb_vld_ff   <= dwb_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_ff <= ex_res;
         if (ex_res.reg_write) begin
            rwb_idx_ff <= ex_res.reg_index;
            rwb_val_ff <= ex_res.reg_value;
         end
         if (ex_res.mem_write) begin
            dwb_idx_ff <= ex_res.mem_index;
            dwb_val_ff <= ex_res.mem_value;
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_next_pc      = out_ff.next_pc;
   assign rsp_halted       = out_ff.halted;
   assign rsp_illegal      = out_ff.illegal;
   assign rsp_branch_taken = out_ff.branch_taken;
   assign rsp_reg_write    = out_ff.reg_write;
   assign rsp_reg_index    = out_ff.reg_index;
   assign rsp_reg_value    = out_ff.reg_value;
   assign rsp_mem_write    = out_ff.mem_write;
   assign rsp_mem_index    = 6'(out_ff.mem_index);
   assign rsp_mem_value    = out_ff.mem_value;

endmodule
